// ===== rtl/counter_priority_task_picker_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the counter priority task picker
// Clocked property checks with reset disable, used by the back end.
// ----------------------------------------------------------------------------
`ifndef COUNTER_PRIORITY_TASK_PICKER_MACROS_SVH
`define COUNTER_PRIORITY_TASK_PICKER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define CPTP_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define CPTP_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cptp_pkg.sv =====
// ----------------------------------------------------------------------------
// Counter priority task picker package
// Field widths, shared types and constants of the task picker.
// ----------------------------------------------------------------------------
package cptp_pkg;

   // Field widths
   localparam int SLOT_INDEX_W = 6;
   localparam int CNT_W        = 16;
   localparam int PRIO_W       = 8;
   localparam int LIMIT_W      = 8;
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // Defaults for top level parameters
   localparam int NUM_SLOTS_DEF   = 64;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Constants
   localparam logic [CNT_W-1:0]   CNT_MAX          = '1;
   localparam logic [PRIO_W-1:0]  RESET_PRIO_SLOT0 = PRIO_W'(1);
   localparam logic [LIMIT_W-1:0] ROUND_LIMIT_RST  = LIMIT_W'(16);

   // Register word index (paddr bit 2 and up)
   localparam logic [0:0] REG_ROUND_LIMIT = 1'b0;

   typedef enum logic {
      OP_WRITE = 1'b0,
      OP_SCHED = 1'b1
   } op_kind_type;

   // Classified command handed from front to back
   typedef struct packed {
      op_kind_type               kind;
      logic                      in_range;
      logic [SLOT_INDEX_W-1:0]   slot_index;
      logic                      valid;
      logic                      running;
      logic [CNT_W-1:0]          counter;
      logic [PRIO_W-1:0]         prio;
   } cptp_op_type;

   // One slot of the counter and priority memory
   typedef struct packed {
      logic [CNT_W-1:0]  counter;
      logic [PRIO_W-1:0] prio;
   } cptp_entry_type;

endpackage

// ===== rtl/cptp_if.sv =====
// ----------------------------------------------------------------------------
// Task picker channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface cptp_req_if;
   import cptp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic                    cmd;
   logic [SLOT_INDEX_W-1:0] slot_index;
   logic                    slot_valid_in;
   logic                    slot_running_in;
   logic [CNT_W-1:0]        counter_in;
   logic [PRIO_W-1:0]       priority_in;

   modport source (output valid, cmd, slot_index, slot_valid_in, slot_running_in,
                   counter_in, priority_in, input ready);
   modport sink (input valid, cmd, slot_index, slot_valid_in, slot_running_in,
                 counter_in, priority_in, output ready);
endinterface

interface cptp_rsp_if;
   import cptp_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [SLOT_INDEX_W-1:0] chosen_slot;
   logic                    switched;
   logic                    no_candidate;

   modport source (output valid, chosen_slot, switched, no_candidate, input ready);
   modport sink (input valid, chosen_slot, switched, no_candidate, output ready);
endinterface

// ===== rtl/cptp_front.sv =====
// ----------------------------------------------------------------------------
// Task picker front end
// Accepts command beats, classifies them and stages them for the queue.
// ----------------------------------------------------------------------------
module cptp_front #(
   parameter int NUM_SLOTS = cptp_pkg::NUM_SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cptp_req_if.sink              req_ch,
   output logic                  push_valid,
   output cptp_pkg::cptp_op_type push_op,
   input  logic                  push_ready
);
   import cptp_pkg::*;

   logic        stage_vld_ff;
   logic        stage_vld_in;
   cptp_op_type stage_op_ff;
   cptp_op_type stage_op_in;
   logic        req_take;

   // Take a beat when the stage is empty or draining into the queue
   assign req_ch.ready = !stage_vld_ff || push_ready;
   assign req_take     = req_ch.valid && req_ch.ready;

   // Classify the command and flag slot indices that fall outside the table
   always_comb begin
      stage_op_in.kind       = req_ch.cmd ? OP_SCHED : OP_WRITE;
      stage_op_in.in_range   = int'(req_ch.slot_index) < NUM_SLOTS;
      stage_op_in.slot_index = req_ch.slot_index;
      stage_op_in.valid      = req_ch.slot_valid_in;
      stage_op_in.running    = req_ch.slot_running_in;
      stage_op_in.counter    = req_ch.counter_in;
      stage_op_in.prio       = req_ch.priority_in;
   end

   assign stage_vld_in = req_take || (stage_vld_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= 1'b0;
      end else begin
         stage_vld_ff <= stage_vld_in;
      end
   end

   // Hold the staged command until the queue takes it
   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_op_ff <= stage_op_in;
      end
   end

   assign push_valid = stage_vld_ff;
   assign push_op    = stage_op_ff;

endmodule

// ===== rtl/cptp_queue.sv =====
// ----------------------------------------------------------------------------
// Task picker command queue
// Short FIFO that decouples command classification from execution.
// ----------------------------------------------------------------------------
module cptp_queue #(
   parameter int DEPTH = cptp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  cptp_pkg::cptp_op_type push_op,
   output logic                  push_ready,
   output logic                  pop_valid,
   output cptp_pkg::cptp_op_type pop_op,
   input  logic                  pop
);
   import cptp_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cptp_op_type             slot_ff [DEPTH];
   logic [PTR_W-1:0]        wr_ptr_ff;
   logic [PTR_W-1:0]        wr_ptr_in;
   logic [PTR_W-1:0]        rd_ptr_ff;
   logic [PTR_W-1:0]        rd_ptr_in;
   logic [CNT_W-1:0]        count_ff;
   logic [CNT_W-1:0]        count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = count_ff < CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed command
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

// ===== rtl/cptp_back.sv =====
// ----------------------------------------------------------------------------
// Task picker back end
// Holds the slot table and runs slot writes and the scan/refill scheduler.
// ----------------------------------------------------------------------------
`include "counter_priority_task_picker_macros.svh"

module cptp_back #(
   parameter int NUM_SLOTS = cptp_pkg::NUM_SLOTS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [cptp_pkg::LIMIT_W-1:0] round_limit,
   input  logic                         q_valid,
   input  cptp_pkg::cptp_op_type        q_head,
   output logic                         q_pop,
   cptp_rsp_if.source                   rsp_ch
);
   import cptp_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int SCAN_W = $clog2(NUM_SLOTS + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_DECIDE = 3'b100
   } back_state_type;

   back_state_type          state_ff;
   back_state_type          state_in;

   // Slot table: marks in flops, counter and priority in memory
   cptp_entry_type          entry_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0]    valid_ff;
   logic [NUM_SLOTS-1:0]    running_ff;
   logic [NUM_SLOTS-1:0]    written_ff;

   // Scan pipeline
   logic [SCAN_W-1:0]       scan_cnt_ff;
   logic [SCAN_W-1:0]       scan_cnt_in;
   logic                    rd_vld_ff;
   logic [SLOT_W-1:0]       rd_slot_ff;
   cptp_entry_type          rd_data_ff;
   logic                    found_ff;
   logic                    found_in;
   logic [CNT_W-1:0]        best_ff;
   logic [CNT_W-1:0]        best_in;
   logic [SLOT_W-1:0]       pick_ff;
   logic [SLOT_W-1:0]       pick_in;
   logic                    refill_ff;
   logic                    refill_in;
   logic [LIMIT_W-1:0]      rounds_ff;
   logic [LIMIT_W-1:0]      rounds_in;
   logic [SLOT_W-1:0]       current_ff;
   logic [SLOT_W-1:0]       current_in;

   // Result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [SLOT_INDEX_W-1:0] rsp_slot_ff;
   logic                    rsp_sw_ff;
   logic                    rsp_none_ff;
   logic                    rsp_load;
   logic [SLOT_INDEX_W-1:0] rsp_slot_in;
   logic                    rsp_sw_in;
   logic                    rsp_none_in;

   logic                    rsp_free;
   logic                    is_write;
   logic                    do_load;
   logic [SLOT_W-1:0]       wr_slot;
   logic                    issuing;
   logic [SLOT_W-1:0]       rd_addr;
   logic                    hit;
   logic [CNT_W-1:0]        eff_cnt;
   logic [PRIO_W-1:0]       eff_prio;
   logic                    slot_live;
   logic                    slot_cand;
   logic [CNT_W:0]          sum;
   logic [CNT_W-1:0]        new_cnt;
   logic                    better;
   logic                    refill_we;
   logic                    pass_done;
   logic                    win;
   logic                    out_of_rounds;
   logic                    mem_we;
   logic [SLOT_W-1:0]       mem_wa;
   cptp_entry_type          mem_wd;

   // Take a command only with room for its result beat
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign q_pop    = (state_ff == ST_IDLE) && q_valid && rsp_free;
   assign is_write = q_head.kind == OP_WRITE;
   assign do_load  = q_pop && is_write && q_head.in_range;
   assign wr_slot  = SLOT_W'(q_head.slot_index);

   // Read side of the scan, one slot a cycle
   assign issuing = (state_ff == ST_SCAN) && (scan_cnt_ff < SCAN_W'(NUM_SLOTS));
   assign rd_addr = scan_cnt_ff[SLOT_W-1:0];

   // Effective slot contents: unwritten entries read as their reset value
   assign hit       = written_ff[rd_slot_ff];
   assign eff_cnt   = hit ? rd_data_ff.counter : '0;
   assign eff_prio  = hit ? rd_data_ff.prio
                          : ((rd_slot_ff == '0) ? RESET_PRIO_SLOT0 : '0);
   assign slot_live = valid_ff[rd_slot_ff];
   assign slot_cand = slot_live && running_ff[rd_slot_ff];

   // Saturating refill, then compare against the best so far
   assign sum       = (CNT_W + 1)'(eff_cnt) + (CNT_W + 1)'(eff_prio);
   assign refill_we = rd_vld_ff && refill_ff && slot_live;
   assign new_cnt   = (refill_ff && slot_live) ? (sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0])
                                               : eff_cnt;
   assign better    = slot_cand && (!found_ff || (new_cnt > best_ff));

   assign pass_done     = (state_ff == ST_SCAN) && !issuing && !rd_vld_ff;
   assign win           = found_ff && (best_ff != '0);
   assign out_of_rounds = rounds_ff >= round_limit;

   // Memory write port: slot write or refill write-back
   always_comb begin
      mem_we = 1'b0;
      mem_wa = '0;
      mem_wd = '0;
      if (do_load) begin
         mem_we         = 1'b1;
         mem_wa         = wr_slot;
         mem_wd.counter = q_head.counter;
         mem_wd.prio    = q_head.prio;
      end else if (refill_we) begin
         mem_we         = 1'b1;
         mem_wa         = rd_slot_ff;
         mem_wd.counter = new_cnt;
         mem_wd.prio    = eff_prio;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem[rd_addr];
      rd_slot_ff <= rd_addr;
   end

   // Slot marks and written flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= NUM_SLOTS'(1);
         running_ff <= NUM_SLOTS'(1);
         written_ff <= '0;
      end else begin
         if (do_load) begin
            valid_ff[wr_slot]   <= q_head.valid;
            running_ff[wr_slot] <= q_head.running;
         end
         if (mem_we) begin
            written_ff[mem_wa] <= 1'b1;
         end
      end
   end

   // Sequencer: scan passes with refills until a pick or the round limit
   always_comb begin
      state_in    = state_ff;
      scan_cnt_in = issuing ? scan_cnt_ff + 1'b1 : scan_cnt_ff;
      found_in    = found_ff;
      best_in     = best_ff;
      pick_in     = pick_ff;
      refill_in   = refill_ff;
      rounds_in   = rounds_ff;
      current_in  = current_ff;
      rsp_load    = 1'b0;
      rsp_slot_in = SLOT_INDEX_W'(current_ff);
      rsp_sw_in   = 1'b0;
      rsp_none_in = 1'b0;
      if (rd_vld_ff && better) begin
         found_in = 1'b1;
         best_in  = new_cnt;
         pick_in  = rd_slot_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (is_write) begin
                  rsp_load = 1'b1;
               end else begin
                  state_in    = ST_SCAN;
                  scan_cnt_in = '0;
                  found_in    = 1'b0;
                  rounds_in   = '0;
                  refill_in   = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            if (pass_done) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (win) begin
               current_in  = pick_ff;
               rsp_load    = 1'b1;
               rsp_slot_in = SLOT_INDEX_W'(pick_ff);
               rsp_sw_in   = pick_ff != current_ff;
               state_in    = ST_IDLE;
            end else if (out_of_rounds) begin
               rsp_load    = 1'b1;
               rsp_none_in = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               rounds_in   = rounds_ff + 1'b1;
               refill_in   = 1'b1;
               scan_cnt_in = '0;
               found_in    = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_cnt_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         found_ff     <= 1'b0;
         refill_ff    <= 1'b0;
         rounds_ff    <= '0;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         rd_vld_ff    <= issuing;
         found_ff     <= found_in;
         refill_ff    <= refill_in;
         rounds_ff    <= rounds_in;
         current_ff   <= current_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Best counter and pick carry no reset: guarded by found
   always_ff @(posedge clock) begin
      best_ff <= best_in;
      pick_ff <= pick_in;
   end

   // Result beat payload
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_slot_ff <= rsp_slot_in;
         rsp_sw_ff   <= rsp_sw_in;
         rsp_none_ff <= rsp_none_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.chosen_slot  = rsp_slot_ff;
   assign rsp_ch.switched     = rsp_sw_ff;
   assign rsp_ch.no_candidate = rsp_none_ff;

   `CPTP_ASSERT_IMP(a_decide_rsp_free, state_ff == ST_DECIDE, !rsp_valid_ff, "result pending at decide")
   `CPTP_ASSERT_IMP(a_pop_idle, q_pop, state_ff == ST_IDLE, "command popped while busy")
   `CPTP_ASSERT_NXT(a_win_current, (state_ff == ST_DECIDE) && win, current_ff == $past(pick_ff), "current slot not updated")
   `CPTP_ASSERT_IMP(a_none_no_switch, rsp_valid_ff && rsp_none_ff, !rsp_sw_ff, "switch flagged without candidate")
   `CPTP_ASSERT_IMP(a_refill_after_miss, refill_we, rounds_ff != '0, "refill in first pass")

endmodule

// ===== rtl/counter_priority_task_picker.sv =====
// ----------------------------------------------------------------------------
// Counter priority task picker
// Slot table with a counter based scheduler: a write beat loads one slot, a
// schedule beat picks the running slot with the largest counter, refilling
// counters by priority when none is positive. A write beat yields its result
// the cycle after it leaves the command queue. A schedule beat takes one scan
// pass, plus one per refill round (at most round_limit + 1 passes): the single
// read port of the counter memory visits one slot a cycle, and a refill round
// writes back in the same pass. Commands queue up in front while the scheduler
// works; round_limit is at byte address 0 of the register port.
// ----------------------------------------------------------------------------
module counter_priority_task_picker #(
   parameter int NUM_SLOTS   = cptp_pkg::NUM_SLOTS_DEF,
   parameter int QUEUE_DEPTH = cptp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   cptp_req_if.sink                        req_ch,
   cptp_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [cptp_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [cptp_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [cptp_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import cptp_pkg::*;

   logic [LIMIT_W-1:0] round_limit_ff;
   logic [LIMIT_W-1:0] round_limit_in;
   logic               csr_wr;
   logic               sel_limit;
   logic               push_valid;
   logic               push_ready;
   cptp_op_type        push_op;
   logic               q_valid;
   cptp_op_type        q_head;
   logic               q_pop;

   // Register port: word decode on the upper address bits
   assign pready    = 1'b1;
   assign sel_limit = paddr[CSR_ADDR_W-1:2] == REG_ROUND_LIMIT;
   assign csr_wr    = psel && penable && pwrite && pready;

   assign round_limit_in = (csr_wr && sel_limit) ? pwdata[LIMIT_W-1:0] : round_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         round_limit_ff <= ROUND_LIMIT_RST;
      end else begin
         round_limit_ff <= round_limit_in;
      end
   end

   assign prdata = sel_limit ? CSR_DATA_W'(round_limit_ff) : '0;

   cptp_front #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready)
   );

   cptp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_op    (push_op),
      .push_ready (push_ready),
      .pop_valid  (q_valid),
      .pop_op     (q_head),
      .pop        (q_pop)
   );

   cptp_back #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .round_limit (round_limit_ff),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_ch      (rsp_ch)
   );

endmodule
